[rtl/bcrhe_pkg.sv]
// Shared types and constants of the button press, release and hold event detector.
package bcrhe_pkg;

   // Number of buttons tracked; buttons at or above the input width never read as pressed.
   localparam int BUTTONS   = 16;
   localparam int BTN_IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   // Field widths fixed by the interface.
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 32;
   localparam int CNT_STEP_W = $clog2(COUNT_W);

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from byte address bits [4:2].
   typedef enum logic [2:0] {
      REG_CLICK_ENABLE   = 3'd0,
      REG_RELEASE_ENABLE = 3'd1,
      REG_HOLD_ENABLE    = 3'd2,
      REG_HOLD_THRESHOLD = 3'd3,
      REG_HOLD_PERIOD    = 3'd4
   } reg_idx_type;

   // Reset value of the hold period register.
   localparam logic [FIELD_W-1:0] HOLD_PERIOD_RESET = FIELD_W'(1);

   // Register file contents as seen by the sequencer.
   typedef struct packed {
      logic [FIELD_W-1:0] click_enable;
      logic [FIELD_W-1:0] release_enable;
      logic [FIELD_W-1:0] hold_enable;
      logic [FIELD_W-1:0] hold_threshold;
      logic [FIELD_W-1:0] hold_period;
   } cfg_type;

   // Status of the shared remainder unit.
   typedef struct packed {
      logic done;
      logic zero;
   } rem_stat_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOD,
      ST_DONE
   } state_type;

endpackage

[rtl/bcrhe_if.sv]
// Valid/ready channel interfaces for tick input beats and event result beats.
interface bcrhe_req_if;
   logic                         valid;
   logic                         ready;
   logic [bcrhe_pkg::FIELD_W-1:0] buttons_pressed;

   modport source (output valid, output buttons_pressed, input ready);
   modport sink   (input valid, input buttons_pressed, output ready);
endinterface

interface bcrhe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bcrhe_pkg::FIELD_W-1:0] press_events;
   logic [bcrhe_pkg::FIELD_W-1:0] release_events;
   logic [bcrhe_pkg::FIELD_W-1:0] hold_events;

   modport source (output valid, output press_events, output release_events,
                   output hold_events, input ready);
   modport sink   (input valid, input press_events, input release_events,
                   input hold_events, output ready);
endinterface

[rtl/bcrhe_csr.sv]
// APB-style configuration register file for the event masks and hold timing.
module bcrhe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bcrhe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bcrhe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bcrhe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output bcrhe_pkg::cfg_type                cfg
);

   bcrhe_pkg::cfg_type  cfg_ff;
   logic                wr_en;
   logic [2:0]          reg_idx;
   logic [bcrhe_pkg::FIELD_W-1:0] wdata;

   // Writes complete in the access phase; the port never stalls.
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign wdata   = pwdata[bcrhe_pkg::FIELD_W-1:0];

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_enable   <= '0;
         cfg_ff.release_enable <= '0;
         cfg_ff.hold_enable    <= '0;
         cfg_ff.hold_threshold <= '0;
         cfg_ff.hold_period    <= bcrhe_pkg::HOLD_PERIOD_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            bcrhe_pkg::REG_CLICK_ENABLE:   cfg_ff.click_enable   <= wdata;
            bcrhe_pkg::REG_RELEASE_ENABLE: cfg_ff.release_enable <= wdata;
            bcrhe_pkg::REG_HOLD_ENABLE:    cfg_ff.hold_enable    <= wdata;
            bcrhe_pkg::REG_HOLD_THRESHOLD: cfg_ff.hold_threshold <= wdata;
            bcrhe_pkg::REG_HOLD_PERIOD:    cfg_ff.hold_period    <= wdata;
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      prdata = '0;
      case (reg_idx)
         bcrhe_pkg::REG_CLICK_ENABLE:
            prdata = bcrhe_pkg::CSR_DATA_W'(cfg_ff.click_enable);
         bcrhe_pkg::REG_RELEASE_ENABLE:
            prdata = bcrhe_pkg::CSR_DATA_W'(cfg_ff.release_enable);
         bcrhe_pkg::REG_HOLD_ENABLE:
            prdata = bcrhe_pkg::CSR_DATA_W'(cfg_ff.hold_enable);
         bcrhe_pkg::REG_HOLD_THRESHOLD:
            prdata = bcrhe_pkg::CSR_DATA_W'(cfg_ff.hold_threshold);
         bcrhe_pkg::REG_HOLD_PERIOD:
            prdata = bcrhe_pkg::CSR_DATA_W'(cfg_ff.hold_period);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bcrhe_rem.sv]
// Bit-serial restoring remainder unit: 32-bit count modulo 16-bit period.
module bcrhe_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bcrhe_pkg::COUNT_W-1:0]     dividend,
   input  logic [bcrhe_pkg::FIELD_W-1:0]     divisor,
   output bcrhe_pkg::rem_stat_type           stat
);

   logic                                 busy_ff,  busy_in;
   logic                                 done_ff,  done_in;
   logic [bcrhe_pkg::CNT_STEP_W-1:0]     step_ff,  step_in;
   logic [bcrhe_pkg::COUNT_W-1:0]        dvd_ff,   dvd_in;
   logic [bcrhe_pkg::FIELD_W-1:0]        rem_ff,   rem_in;
   logic [bcrhe_pkg::FIELD_W-1:0]        div_ff,   div_in;
   logic [bcrhe_pkg::FIELD_W:0]          trial;
   logic [bcrhe_pkg::FIELD_W:0]          diff;

   // One quotient bit per cycle: shift in the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, dvd_ff[bcrhe_pkg::COUNT_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[bcrhe_pkg::COUNT_W-2:0], 1'b0};
         rem_in  = (trial >= {1'b0, div_ff}) ? diff[bcrhe_pkg::FIELD_W-1:0]
                                             : trial[bcrhe_pkg::FIELD_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == bcrhe_pkg::CNT_STEP_W'(bcrhe_pkg::COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

endmodule

[rtl/button_click_release_hold_events.sv]
// Top level: per-button press, release and hold-repeat event detector.
//
// Each tick beat carries the pressed bit of every button; the block answers with one result
// beat of press, release and hold event masks. A sequencer visits the buttons one per cycle,
// pausing on a button while its remainder check runs, and reads and updates a 32-bit
// pressed-tick count for each. Only a button that is pressed, hold-enabled, past the hold
// threshold and under a nonzero period needs its count taken modulo the period, and that
// goes through one shared bit-serial remainder unit, so a tick is worked on longer for each
// button that needs the check. The input side is not ready while a tick is being worked on;
// a finished result waits in an output register and the next tick is accepted while it does.
// Counts clear at reset with no extra pass.
module button_click_release_hold_events (
   input  logic                              clock,
   input  logic                              reset,
   bcrhe_req_if.sink                         req,
   bcrhe_rsp_if.source                       rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bcrhe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bcrhe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bcrhe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   localparam int BTN  = bcrhe_pkg::BUTTONS;
   localparam int IW   = bcrhe_pkg::BTN_IDX_W;
   localparam int FW   = bcrhe_pkg::FIELD_W;
   localparam int CW   = bcrhe_pkg::COUNT_W;

   bcrhe_pkg::cfg_type       cfg;
   bcrhe_pkg::rem_stat_type  rem_stat;
   bcrhe_pkg::state_type     state_ff, state_in;

   logic [CW-1:0]  count_ff [BTN];
   logic [IW-1:0]  idx_ff;
   logic [FW-1:0]  bits_ff;
   logic [FW-1:0]  press_acc_ff, release_acc_ff, hold_acc_ff;
   logic [FW-1:0]  press_res_ff, release_res_ff, hold_res_ff;
   logic           rsp_valid_ff;

   logic [FW-1:0]  bit_mask;
   logic [CW-1:0]  cnt;
   logic           pressed;
   logic           need_mod;
   logic           is_last;
   logic           out_free;

   logic           accept;
   logic           rem_start;
   logic           finish_btn;
   logic           hold_hit;
   logic           load_rsp;
   logic [CW-1:0]  count_in;

   // Configuration registers.
   bcrhe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Shared modulo unit.
   bcrhe_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cnt),
      .divisor  (cfg.hold_period),
      .stat     (rem_stat)
   );

   // Current button: its one-hot bit (zero beyond the input width), count and pressed state.
   assign bit_mask = FW'(1) << idx_ff;
   assign cnt      = count_ff[idx_ff];
   assign pressed  = |(bits_ff & bit_mask);
   assign need_mod = pressed && (|(cfg.hold_enable & bit_mask)) &&
                     (cfg.hold_period != '0) && (cnt > CW'(cfg.hold_threshold));
   assign is_last  = (idx_ff == IW'(BTN - 1));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign count_in = pressed ? (cnt + 1'b1) : '0;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcrhe_pkg::ST_IDLE: begin
            if (req.valid) state_in = bcrhe_pkg::ST_SCAN;
         end
         bcrhe_pkg::ST_SCAN: begin
            if (need_mod)     state_in = bcrhe_pkg::ST_MOD;
            else if (is_last) state_in = bcrhe_pkg::ST_DONE;
         end
         bcrhe_pkg::ST_MOD: begin
            if (rem_stat.done) begin
               state_in = is_last ? bcrhe_pkg::ST_DONE : bcrhe_pkg::ST_SCAN;
            end
         end
         bcrhe_pkg::ST_DONE: begin
            if (out_free) state_in = bcrhe_pkg::ST_IDLE;
         end
         default: state_in = bcrhe_pkg::ST_IDLE;
      endcase
   end

   // Output and control decode.
   always_comb begin
      accept     = 1'b0;
      rem_start  = 1'b0;
      finish_btn = 1'b0;
      hold_hit   = 1'b0;
      load_rsp   = 1'b0;
      req.ready  = 1'b0;
      case (state_ff)
         bcrhe_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            accept    = req.valid;
         end
         bcrhe_pkg::ST_SCAN: begin
            rem_start  = need_mod;
            finish_btn = !need_mod;
         end
         bcrhe_pkg::ST_MOD: begin
            finish_btn = rem_stat.done;
            hold_hit   = rem_stat.done && rem_stat.zero;
         end
         bcrhe_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcrhe_pkg::ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            idx_ff <= '0;
         end else if (finish_btn && !is_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pressed-tick counts, cleared at reset and written once per visited button.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BTN; i++) begin
            count_ff[i] <= '0;
         end
      end else if (finish_btn) begin
         count_ff[idx_ff] <= count_in;
      end
   end

   // Tick beat capture and event accumulation.
   always_ff @(posedge clock) begin
      if (accept) begin
         bits_ff        <= req.buttons_pressed;
         press_acc_ff   <= '0;
         release_acc_ff <= '0;
         hold_acc_ff    <= '0;
      end else begin
         if (finish_btn) begin
            if (pressed && (cnt == '0)) begin
               press_acc_ff <= press_acc_ff | (bit_mask & cfg.click_enable);
            end
            if (!pressed && (cnt != '0)) begin
               release_acc_ff <= release_acc_ff | (bit_mask & cfg.release_enable);
            end
         end
         if (hold_hit) begin
            hold_acc_ff <= hold_acc_ff | (bit_mask & cfg.hold_enable);
         end
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         press_res_ff   <= press_acc_ff;
         release_res_ff <= release_acc_ff;
         hold_res_ff    <= hold_acc_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.press_events   = press_res_ff;
   assign rsp.release_events = release_res_ff;
   assign rsp.hold_events    = hold_res_ff;

endmodule
